// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and constants for the cell chain and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int Depth    = 16;
  localparam int KeyW     = 31;
  localparam int PayloadW = 64;
  localparam int CountW   = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    CmdEnqueue = 2'd0,
    CmdDequeue = 2'd1,
    CmdClear   = 2'd2,
    CmdNop     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2,
    StatusRsvd  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [KeyW-1:0]     out_key;
    logic [PayloadW-1:0] out_payload;
    logic [CountW-1:0]   count;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } entry_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on insert keeps, takes the new entry or takes the left
// neighbor; on remove takes the right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      occupied_i,
  input  logic      left_le_i,
  input  entry_t    left_entry_i,
  input  entry_t    right_entry_i,
  output entry_t    entry_o,
  output logic      le_o
);

  entry_t entry_q;
  entry_t entry_d;

  // Stored entry orders at or before the incoming key.
  assign le_o = occupied_i && (entry_q.key <= ctl_i.new_entry.key);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert) begin
      priority if (le_o) begin
        entry_d = entry_q;
      end else if (left_le_i) begin
        entry_d = ctl_i.new_entry;
      end else begin
        entry_d = left_entry_i;
      end
    end else if (ctl_i.remove) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue top level
// Request register, count and response logic around a chain of cells.
// ----------------------------------------------------------------------------
// Usage: drive req_i with a command (enqueue, dequeue, clear) and raise
// start. The request is taken at a rising edge with start high and busy
// low. busy is high for one cycle after that while the cell chain acts on
// the request; in that same cycle the cells shift and the response is
// registered. The response shows on rsp_o for exactly one cycle, marked by
// done_o, which is registered from busy. It cannot be held off, so the
// receiver must take it in that cycle.
// A new request is taken only while busy is low, so one request is in
// flight at a time; this is set by the request register followed by the
// parallel compare and shift in the cells, and it does not depend on how
// many entries are held.
// Every response carries the entry count after the operation. A dequeue
// on an empty queue reports empty status; an enqueue on a full queue
// reports full status and leaves the queue unchanged.
// Reset empties the queue and drops any request in flight; the cells
// themselves are not cleared, only the count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  req_t              req_q;
  logic              req_valid_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  rsp_t              rsp_q;
  rsp_t              rsp_d;
  logic              done_q;

  logic      accept;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;

  entry_t entries [Depth];
  logic   le      [Depth];

  assign accept = start && !busy;
  assign busy   = req_valid_q;
  assign full   = (count_q == CountW'(Depth));
  assign empty  = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
      count_q     <= '0;
    end else begin
      req_valid_q <= accept;
      done_q      <= req_valid_q;
      count_q     <= count_d;
    end
  end

  // Hold the request for the cell cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  always_comb begin
    ctl.insert    = req_valid_q && (cmd_e'(req_q.cmd) == CmdEnqueue) && !full;
    ctl.remove    = req_valid_q && (cmd_e'(req_q.cmd) == CmdDequeue) && !empty;
    ctl.new_entry = '{key: req_q.key, payload: req_q.payload};
  end

  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    if (req_valid_q) begin
      unique case (cmd_e'(req_q.cmd))
        CmdEnqueue: begin
          if (full) begin
            rsp_d.status = StatusFull;
          end else begin
            count_d = count_q + CountW'(1);
          end
        end
        CmdDequeue: begin
          if (empty) begin
            rsp_d.status = StatusEmpty;
          end else begin
            count_d           = count_q - CountW'(1);
            rsp_d.out_key     = entries[0].key;
            rsp_d.out_payload = entries[0].payload;
          end
        end
        CmdClear: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
      rsp_d.count = count_d;
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic   occupied;
    logic   left_le;
    entry_t left_entry;
    entry_t right_entry;

    assign occupied = (CountW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_le    = 1'b1;
      assign left_entry = ctl.new_entry;
    end else begin : g_body
      assign left_le    = le[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_entry = ctl.new_entry;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occupied_i    (occupied),
      .left_le_i     (left_le),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entries[i]),
      .le_o          (le[i])
    );
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("entry count above depth");

  a_done_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> done_o)
    else $error("response missing after request");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && cmd_e'(req_q.cmd) == CmdClear) |=> (count_q == '0))
    else $error("clear left entries");

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.count == count_q))
    else $error("reported count differs from held count");

  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.insert || ctl.remove) |-> (full != ctl.insert || !ctl.insert)
      && !(ctl.insert && ctl.remove))
    else $error("cell chain control conflict");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives enqueue, dequeue, clear and unused commands with random gaps,
// tracks the sorted store on the side and checks every response field.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 1200;
  localparam int ReportLimit = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  int unsigned cycle_count = 0;

  // Shadow copy of the sorted store plus the responses still owed.
  class spq_scoreboard;
    logic [KeyW-1:0]     held_keys[Depth];
    logic [PayloadW-1:0] held_payloads[Depth];
    int unsigned         held_count;
    rsp_t                expected_rsp[$];
    int unsigned         mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function void take_request(req_t r);
      rsp_t        rsp;
      int unsigned slot;
      rsp = '0;
      rsp.status = StatusOk;
      case (r.cmd)
        CmdEnqueue: begin
          if (held_count >= Depth) begin
            rsp.status = StatusFull;
          end else begin
            // Insert behind every entry with an equal or smaller key.
            slot = 0;
            while (slot < held_count && held_keys[slot] <= r.key) slot++;
            for (int i = held_count; i > slot; i--) begin
              held_keys[i]     = held_keys[i-1];
              held_payloads[i] = held_payloads[i-1];
            end
            held_keys[slot]     = r.key;
            held_payloads[slot] = r.payload;
            held_count++;
          end
        end
        CmdDequeue: begin
          if (held_count == 0) begin
            rsp.status = StatusEmpty;
          end else begin
            rsp.out_key     = held_keys[0];
            rsp.out_payload = held_payloads[0];
            for (int i = 1; i < held_count; i++) begin
              held_keys[i-1]     = held_keys[i];
              held_payloads[i-1] = held_payloads[i];
            end
            held_count--;
          end
        end
        CmdClear: held_count = 0;
        default: ;
      endcase
      rsp.count = CountW'(held_count);
      expected_rsp.push_back(rsp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("Unexpected response: status %0d key %h payload %h count %0d",
                   got.status, got.out_key, got.out_payload, got.count);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status || got.out_key !== want.out_key ||
          got.out_payload !== want.out_payload || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("Response mismatch: expected status %0d key %h payload %h count %0d",
                   want.status, want.out_key, want.out_payload, want.count);
          $display("                   actual   status %0d key %h payload %h count %0d",
                   got.status, got.out_key, got.out_payload, got.count);
        end
      end
    endfunction
  endclass

  spq_scoreboard scoreboard = new();

  sorted_priority_queue_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) scoreboard.take_request(req_i);
      if (done_o) scoreboard.check_response(rsp_o);
    end
  end

  // Hold the request until it is taken; leave start high for back-to-back use.
  task automatic send_request(input cmd_e op, input logic [KeyW-1:0] k,
                              input logic [PayloadW-1:0] p);
    req_t r;
    r.cmd     = op;
    r.key     = k;
    r.payload = p;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (scoreboard.expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor a few small keys so equal keys meet often in the store.
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return KeyW'($urandom_range(0, 7));
    if (roll == 4) return '0;
    if (roll == 5) return '1;
    return KeyW'($urandom);
  endfunction

  function automatic cmd_e pick_cmd(input bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return CmdClear;
    if (roll < 5) return CmdNop;
    if (filling) return (roll < 78) ? CmdEnqueue : CmdDequeue;
    return (roll < 78) ? CmdDequeue : CmdEnqueue;
  endfunction

  initial begin
    bit          filling;
    bit          no_idle;
    int unsigned phase_left;
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, unused command, field extremes, equal keys in arrival order.
    send_request(CmdDequeue, '0, '0);
    send_request(CmdNop, '1, '1);
    send_request(CmdEnqueue, '1, '1);
    send_request(CmdEnqueue, '0, '0);
    send_request(CmdEnqueue, KeyW'(5), 64'h0000_0000_0000_0001);
    send_request(CmdEnqueue, KeyW'(5), 64'h0000_0000_0000_0002);
    hold_off(3);
    send_request(CmdDequeue, '0, '0);
    send_request(CmdDequeue, '1, '1);
    send_request(CmdClear, '0, '0);
    send_request(CmdDequeue, '0, '0);
    wait_drained();

    // Fill with descending key pairs, then push past full.
    for (int i = 0; i < Depth; i++)
      send_request(CmdEnqueue, KeyW'((Depth - i) / 2), PayloadW'(i));
    send_request(CmdEnqueue, '0, '1);
    send_request(CmdDequeue, '0, '0);
    send_request(CmdClear, '0, '0);

    filling    = 1'b0;
    no_idle    = 1'b0;
    phase_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      // Alternate fill and drain phases so both full and empty get hit.
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(10, 60);
        no_idle    = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      send_request(pick_cmd(filling), pick_key(), {$urandom, $urandom});
      if ($urandom_range(0, 199) == 0) wait_drained();
      else if (!no_idle) hold_off(pick_gap());
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (scoreboard.mismatches == 0 && scoreboard.expected_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
verif/testbench.sv
